// ===== design/ttip_pkg.sv =====
// Shared types, constants and character helpers for the text to integer parser.
`default_nettype none

package ttip_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int OFFSET_BITS = 16;
   localparam int BASE_BITS   = 6;
   localparam int CH_BITS     = 8;

   // response tdata layout, lowest bit first
   localparam int RSP_VALUE_LSB  = 0;
   localparam int RSP_OVF_BIT    = VALUE_BITS;
   localparam int RSP_CONV_BIT   = VALUE_BITS + 1;
   localparam int RSP_OFFSET_LSB = VALUE_BITS + 2;
   localparam int RSP_USED_BITS  = VALUE_BITS + 2 + OFFSET_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_USED_BITS + 7) / 8) * 8;

   // configuration register indexes
   localparam logic CSR_RADIX    = 1'b0;
   localparam logic CSR_UNSIGNED = 1'b1;

   localparam logic [BASE_BITS-1:0] RADIX_RESET = BASE_BITS'(10);
   localparam logic [BASE_BITS-1:0] BASE_OCT    = BASE_BITS'(8);
   localparam logic [BASE_BITS-1:0] BASE_DEC    = BASE_BITS'(10);
   localparam logic [BASE_BITS-1:0] BASE_HEX    = BASE_BITS'(16);
   // above every legal digit, so it never passes a base check
   localparam logic [BASE_BITS-1:0] NOT_DIGIT   = '1;

   localparam logic [CH_BITS-1:0] CH_TAB   = 8'h09;
   localparam logic [CH_BITS-1:0] CH_CR    = 8'h0d;
   localparam logic [CH_BITS-1:0] CH_SPACE = 8'h20;
   localparam logic [CH_BITS-1:0] CH_PLUS  = 8'h2b;
   localparam logic [CH_BITS-1:0] CH_MINUS = 8'h2d;
   localparam logic [CH_BITS-1:0] CH_0     = 8'h30;
   localparam logic [CH_BITS-1:0] CH_9     = 8'h39;
   localparam logic [CH_BITS-1:0] CH_UA    = 8'h41;
   localparam logic [CH_BITS-1:0] CH_UX    = 8'h58;
   localparam logic [CH_BITS-1:0] CH_UZ    = 8'h5a;
   localparam logic [CH_BITS-1:0] CH_LA    = 8'h61;
   localparam logic [CH_BITS-1:0] CH_LX    = 8'h78;
   localparam logic [CH_BITS-1:0] CH_LZ    = 8'h7a;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_WS,
      PH_BODY,
      PH_ZERO,
      PH_ZEROX,
      PH_DIG,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      BOP_HOLD,   // keep effective base
      BOP_RADIX,  // raw radix, 0 or 16 after a leading zero
      BOP_NEW,    // radix, 0 read as decimal
      BOP_ZERO,   // octal or hex after a leading zero
      BOP_HEX     // hex after the 0x prefix
   } base_op_type;

   typedef struct packed {
      logic        clear;
      logic        adv;
      logic        set_neg;
      logic        take;
      logic        mark_any;
      logic        emit;
      base_op_type base_op;
   } cmd_type;

   typedef struct packed {
      logic is_space;
      logic is_sign;
      logic is_zero;
      logic is_x;
      logic is_hex;
      logic auto_radix;
      logic ok_new;
      logic ok_zero;
      logic ok_cur;
   } status_type;

   function automatic logic [BASE_BITS-1:0] digit_of(input logic [CH_BITS-1:0] c);
      logic [BASE_BITS-1:0] d;
      d = NOT_DIGIT;
      if (c inside {[CH_0:CH_9]}) begin
         d = BASE_BITS'(c - CH_0);
      end else if (c inside {[CH_LA:CH_LZ]}) begin
         d = BASE_BITS'(c - CH_LA + 8'd10);
      end else if (c inside {[CH_UA:CH_UZ]}) begin
         d = BASE_BITS'(c - CH_UA + 8'd10);
      end
      return d;
   endfunction

   function automatic logic is_space(input logic [CH_BITS-1:0] c);
      return (c == CH_SPACE) || (c inside {[CH_TAB:CH_CR]});
   endfunction

endpackage

`default_nettype wire

// ===== design/ttip_ctrl.sv =====
// Phase sequencer and result valid flag of the text to integer parser.
`default_nettype none

module ttip_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic               start,
   input  wire ttip_pkg::status_type status,
   input  wire logic               rsp_tready,
   output ttip_pkg::cmd_type       cmd,
   output logic                    rsp_tvalid
);

   ttip_pkg::phase_type phase_ff, phase_in, phase_cur;
   logic                valid_ff, valid_in;

   // a start flag reopens the string whatever the phase
   assign phase_cur = start ? ttip_pkg::PH_WS : phase_ff;

   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         phase_in = phase_cur;
         case (phase_cur)
            ttip_pkg::PH_WS, ttip_pkg::PH_BODY: begin
               if (phase_cur == ttip_pkg::PH_WS && status.is_space) begin
                  phase_in = ttip_pkg::PH_WS;
               end else if (phase_cur == ttip_pkg::PH_WS && status.is_sign) begin
                  phase_in = ttip_pkg::PH_BODY;
               end else if (status.auto_radix && status.is_zero) begin
                  phase_in = ttip_pkg::PH_ZERO;
               end else begin
                  phase_in = status.ok_new ? ttip_pkg::PH_DIG : ttip_pkg::PH_DONE;
               end
            end
            ttip_pkg::PH_ZERO: begin
               if (status.is_x) begin
                  phase_in = ttip_pkg::PH_ZEROX;
               end else begin
                  phase_in = status.ok_zero ? ttip_pkg::PH_DIG : ttip_pkg::PH_DONE;
               end
            end
            ttip_pkg::PH_ZEROX: begin
               phase_in = status.is_hex ? ttip_pkg::PH_DIG : ttip_pkg::PH_DONE;
            end
            ttip_pkg::PH_DIG: begin
               phase_in = status.ok_cur ? ttip_pkg::PH_DIG : ttip_pkg::PH_DONE;
            end
            default: begin
               phase_in = phase_cur;
            end
         endcase
      end
   end

   always_comb begin
      cmd         = '0;
      cmd.base_op = ttip_pkg::BOP_HOLD;
      if (fire) begin
         cmd.clear = start;
         case (phase_cur)
            ttip_pkg::PH_WS, ttip_pkg::PH_BODY: begin
               if (phase_cur == ttip_pkg::PH_WS && status.is_space) begin
                  cmd.adv = 1'b1;
               end else if (phase_cur == ttip_pkg::PH_WS && status.is_sign) begin
                  cmd.adv     = 1'b1;
                  cmd.set_neg = 1'b1;
               end else if (status.auto_radix && status.is_zero) begin
                  cmd.adv     = 1'b1;
                  cmd.base_op = ttip_pkg::BOP_RADIX;
               end else begin
                  cmd.base_op = ttip_pkg::BOP_NEW;
                  cmd.take    = 1'b1;
                  cmd.emit    = !status.ok_new;
               end
            end
            ttip_pkg::PH_ZERO: begin
               if (!status.is_x) begin
                  cmd.base_op  = ttip_pkg::BOP_ZERO;
                  cmd.mark_any = 1'b1;
                  cmd.take     = 1'b1;
                  cmd.emit     = !status.ok_zero;
               end
            end
            ttip_pkg::PH_ZEROX: begin
               if (status.is_hex) begin
                  // the x counts once a hex digit confirms the prefix
                  cmd.base_op = ttip_pkg::BOP_HEX;
                  cmd.adv     = 1'b1;
                  cmd.take    = 1'b1;
               end else begin
                  cmd.mark_any = 1'b1;
                  cmd.emit     = 1'b1;
               end
            end
            ttip_pkg::PH_DIG: begin
               cmd.take = 1'b1;
               cmd.emit = !status.ok_cur;
            end
            default: begin
               cmd.take = 1'b0;
            end
         endcase
      end
   end

   always_comb begin
      valid_in = valid_ff;
      if (cmd.emit) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= ttip_pkg::PH_IDLE;
         valid_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_tvalid = valid_ff;

endmodule

`default_nettype wire

// ===== design/ttip_dpath.sv =====
// Datapath of the text to integer parser: registers, base select, multiply-add and result.
`default_nettype none

module ttip_dpath (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire ttip_pkg::cmd_type                      cmd,
   input  wire logic [ttip_pkg::CH_BITS-1:0]           req_ch,
   input  wire logic                                   csr_write,
   input  wire logic                                   csr_index,
   input  wire logic [ttip_pkg::BASE_BITS-1:0]         csr_wdata,
   output ttip_pkg::status_type                        status,
   output logic [ttip_pkg::RSP_DATA_BITS-1:0]          rsp_data
);

   localparam int N         = ttip_pkg::VALUE_BITS;
   localparam int OB        = ttip_pkg::OFFSET_BITS;
   localparam int BB        = ttip_pkg::BASE_BITS;
   localparam int PROD_BITS = N + BB;
   localparam int SUM_BITS  = PROD_BITS + 1;

   logic [BB-1:0] radix_ff, radix_in;
   logic          unsigned_ff, unsigned_in;
   logic [BB-1:0] base_ff, base_in;
   logic          neg_ff, neg_in;
   logic          ovf_ff, ovf_in;
   logic          any_ff, any_in;
   logic [N-1:0]  acc_ff, acc_in;
   logic [OB-1:0] pos_ff, pos_in;
   logic [ttip_pkg::RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic [BB-1:0]        digit, base_new, base_zero, base_cur, base_take;
   logic                 neg_cur, ovf_cur, any_cur;
   logic [N-1:0]         acc_cur, limit, value;
   logic [OB-1:0]        pos_cur;
   logic [PROD_BITS-1:0] prod;
   logic [SUM_BITS-1:0]  sum;
   logic                 take_ok, ovf_hit;
   logic [1:0]           pos_inc;
   logic [OB:0]          pos_sum;

   // configuration
   always_comb begin
      radix_in    = radix_ff;
      unsigned_in = unsigned_ff;
      if (csr_write) begin
         case (csr_index)
            ttip_pkg::CSR_RADIX:    radix_in    = csr_wdata;
            ttip_pkg::CSR_UNSIGNED: unsigned_in = csr_wdata[0];
            default:                radix_in    = radix_ff;
         endcase
      end
   end

   // character classes
   assign digit     = ttip_pkg::digit_of(req_ch);
   assign base_new  = (radix_ff == '0) ? ttip_pkg::BASE_DEC : radix_ff;
   assign base_zero = (base_ff == '0) ? ttip_pkg::BASE_OCT : ttip_pkg::BASE_HEX;
   assign base_cur  = (base_ff == '0) ? ttip_pkg::BASE_DEC : base_ff;

   always_comb begin
      status            = '0;
      status.is_space   = ttip_pkg::is_space(req_ch);
      status.is_sign    = (req_ch == ttip_pkg::CH_PLUS) || (req_ch == ttip_pkg::CH_MINUS);
      status.is_zero    = (req_ch == ttip_pkg::CH_0);
      status.is_x       = (req_ch == ttip_pkg::CH_LX) || (req_ch == ttip_pkg::CH_UX);
      status.is_hex     = (digit < ttip_pkg::BASE_HEX);
      status.auto_radix = (radix_ff == '0) || (radix_ff == ttip_pkg::BASE_HEX);
      status.ok_new     = (digit < base_new);
      status.ok_zero    = (digit < base_zero);
      status.ok_cur     = (digit < base_cur);
   end

   // a new string starts from cleared state in the same cycle
   assign neg_cur = cmd.clear ? 1'b0 : neg_ff;
   assign ovf_cur = cmd.clear ? 1'b0 : ovf_ff;
   assign any_cur = cmd.clear ? 1'b0 : any_ff;
   assign acc_cur = cmd.clear ? '0 : acc_ff;
   assign pos_cur = cmd.clear ? '0 : pos_ff;

   always_comb begin
      case (cmd.base_op)
         ttip_pkg::BOP_HOLD:  base_in = base_ff;
         ttip_pkg::BOP_RADIX: base_in = radix_ff;
         ttip_pkg::BOP_NEW:   base_in = base_new;
         ttip_pkg::BOP_ZERO:  base_in = base_zero;
         ttip_pkg::BOP_HEX:   base_in = ttip_pkg::BASE_HEX;
         default:             base_in = base_ff;
      endcase
   end

   assign base_take = (base_in == '0) ? ttip_pkg::BASE_DEC : base_in;
   assign take_ok   = cmd.take && (digit < base_take);

   assign neg_in = cmd.set_neg ? (req_ch == ttip_pkg::CH_MINUS) : neg_cur;

   // limit is the magnitude bound: all ones unsigned, 2^(N-1) for minus, else 2^(N-1)-1
   always_comb begin
      if (unsigned_ff) begin
         limit = '1;
      end else if (neg_in) begin
         limit = {1'b1, {(N-1){1'b0}}};
      end else begin
         limit = {1'b0, {(N-1){1'b1}}};
      end
   end

   // acc*base+d above the limit is the same test as acc > cut or acc == cut and d > rem
   assign prod    = PROD_BITS'(acc_cur) * PROD_BITS'(base_take);
   assign sum     = SUM_BITS'(prod) + SUM_BITS'(digit);
   assign ovf_hit = ovf_cur || (sum > SUM_BITS'(limit));

   assign acc_in = (take_ok && !ovf_hit) ? sum[N-1:0] : acc_cur;
   assign ovf_in = take_ok ? ovf_hit : ovf_cur;
   assign any_in = any_cur || take_ok || cmd.mark_any;

   assign pos_inc = {1'b0, cmd.adv} + {1'b0, take_ok};
   assign pos_sum = {1'b0, pos_cur} + (OB+1)'(pos_inc);
   assign pos_in  = pos_sum[OB] ? '1 : pos_sum[OB-1:0];

   always_comb begin
      if (ovf_in) begin
         if (unsigned_ff) begin
            value = '1;
         end else if (neg_in) begin
            value = {1'b1, {(N-1){1'b0}}};
         end else begin
            value = {1'b0, {(N-1){1'b1}}};
         end
      end else begin
         value = neg_in ? (~acc_in + N'(1)) : acc_in;
      end
   end

   always_comb begin
      rsp_data_in = rsp_data_ff;
      if (cmd.emit) begin
         rsp_data_in = '0;
         rsp_data_in[ttip_pkg::RSP_VALUE_LSB +: N]   = value;
         rsp_data_in[ttip_pkg::RSP_OVF_BIT]          = ovf_in;
         rsp_data_in[ttip_pkg::RSP_CONV_BIT]         = any_in;
         rsp_data_in[ttip_pkg::RSP_OFFSET_LSB +: OB] = any_in ? pos_in : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radix_ff    <= ttip_pkg::RADIX_RESET;
         unsigned_ff <= 1'b0;
         base_ff     <= ttip_pkg::BASE_DEC;
         neg_ff      <= 1'b0;
         ovf_ff      <= 1'b0;
         any_ff      <= 1'b0;
         acc_ff      <= '0;
         pos_ff      <= '0;
      end else begin
         radix_ff    <= radix_in;
         unsigned_ff <= unsigned_in;
         base_ff     <= base_in;
         neg_ff      <= neg_in;
         ovf_ff      <= ovf_in;
         any_ff      <= any_in;
         acc_ff      <= acc_in;
         pos_ff      <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

// ===== design/text_to_integer_parser_unit.sv =====
// Streaming string to integer converter: top level with handshakes.
// Takes one character per cycle while no result is stalled; each character is processed in the cycle of its transfer.
// The result register loads at the transfer of the character that ends the number;
// rsp_tvalid rises in the next cycle.
// The multiply-add and limit compare of the digit step are combinational.
// While a result waits on rsp_tready, no character is taken.
// Synchronous active-high reset: no string open, radix 10, signed mode, no result pending.
`default_nettype none

module text_to_integer_parser_unit (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // character stream
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   input  wire logic [7:0]                            req_tdata,  // [7:0] ch
   input  wire logic                                  req_tuser,  // [0] start_req
   // results
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // [31:0] value, [32] overflow, [33] converted, [49:34] end_offset, rest zero
   output logic [ttip_pkg::RSP_DATA_BITS-1:0]         rsp_tdata,
   // configuration writes
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic                                  csr_index,  // 0 radix, 1 unsigned_mode
   input  wire logic [ttip_pkg::BASE_BITS-1:0]        csr_wdata
);

   ttip_pkg::cmd_type    cmd;
   ttip_pkg::status_type status;
   logic                 fire;

   assign req_tready = !rsp_tvalid || rsp_tready;
   assign fire       = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   ttip_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .start      (req_tuser),
      .status     (status),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .rsp_tvalid (rsp_tvalid)
   );

   ttip_dpath u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_ch    (req_tdata),
      .csr_write (csr_valid && csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .status    (status),
      .rsp_data  (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== design/ttip_check.sv =====
// Port-level checker for the text to integer parser, with its bind.
`default_nettype none

module ttip_check (
   input wire logic                                  clock,
   input wire logic                                  reset,
   input wire logic                                  req_tready,
   input wire logic                                  rsp_tvalid,
   input wire logic                                  rsp_tready,
   input wire logic [ttip_pkg::RSP_DATA_BITS-1:0]    rsp_tdata
);

   localparam int N  = ttip_pkg::VALUE_BITS;
   localparam int OB = ttip_pkg::OFFSET_BITS;

   logic          ovf, conv;
   logic [N-1:0]  val;
   logic [OB-1:0] off;

   assign ovf  = rsp_tdata[ttip_pkg::RSP_OVF_BIT];
   assign conv = rsp_tdata[ttip_pkg::RSP_CONV_BIT];
   assign val  = rsp_tdata[ttip_pkg::RSP_VALUE_LSB +: N];
   assign off  = rsp_tdata[ttip_pkg::RSP_OFFSET_LSB +: OB];

   // held result stays put until its transfer
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   // no digit read: everything else is zero
   a_no_digit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !conv |-> (val == '0) && !ovf && (off == '0))
      else $error("unconverted result carries data");

   a_ovf_conv: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && ovf |-> conv)
      else $error("overflow without digits");

   // a stalled result blocks the character stream
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("character taken while result stalled");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result pending after reset");

endmodule

bind text_to_integer_parser_unit ttip_check u_ttip_check (.*);

`default_nettype wire

// ===== dv/text_to_integer_parser_unit_check.sv =====
// Checker for the text to integer parser: watches all channels, predicts each result and compares.
module text_to_integer_parser_unit_check
   import ttip_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   input  wire logic                       req_tready,
   input  wire logic [7:0]                 req_tdata,
   input  wire logic                       req_tuser,
   input  wire logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire logic [RSP_DATA_BITS-1:0]   rsp_tdata,
   input  wire logic                       csr_valid,
   input  wire logic                       csr_ready,
   input  wire logic                       csr_index,
   input  wire logic [BASE_BITS-1:0]       csr_wdata,
   output int                              failures,
   output int                              pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NO_DIGIT = 99;
   localparam logic [OFFSET_BITS-1:0] POS_MAX = '1;

   typedef struct packed {
      logic [VALUE_BITS-1:0]  value;
      logic                   overflow;
      logic                   converted;
      logic [OFFSET_BITS-1:0] offset;
   } conversion_t;

   conversion_t awaited[$];
   int fail_n = 0;

   // parser image
   phase_type              stage = PH_IDLE;
   logic                   neg = 1'b0;
   logic                   ovf = 1'b0;
   logic                   got_digit = 1'b0;
   logic [VALUE_BITS-1:0]  acc = '0;
   logic [BASE_BITS-1:0]   base = BASE_DEC;
   logic [OFFSET_BITS-1:0] pos = '0;
   logic [BASE_BITS-1:0]   radix_reg = RADIX_RESET;
   logic                   unsigned_reg = 1'b0;

   function automatic int char_value(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9) return int'(c - CH_0);
      if (c >= CH_LA && c <= CH_LZ) return int'(c - CH_LA) + 10;
      if (c >= CH_UA && c <= CH_UZ) return int'(c - CH_UA) + 10;
      return NO_DIGIT;
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
   endfunction

   task automatic bump();
      if (pos != POS_MAX) pos = pos + 1'b1;
   endtask

   task automatic close_number(output conversion_t r);
      if (ovf) begin
         if (unsigned_reg) r.value = '1;
         else if (neg) r.value = {1'b1, {(VALUE_BITS-1){1'b0}}};
         else r.value = {1'b0, {(VALUE_BITS-1){1'b1}}};
      end else begin
         r.value = neg ? VALUE_BITS'(0) - acc : acc;
      end
      r.overflow  = ovf;
      r.converted = got_digit;
      r.offset    = got_digit ? pos : '0;
      stage = PH_DONE;
   endtask

   task automatic take_digit(input logic [7:0] c, output bit done, output conversion_t r);
      longint unsigned b, lim, cut, rem;
      int d;
      d = char_value(c);
      b = (base != 0) ? longint'(base) : 10;
      done = 1'b0;
      r = '0;
      if (longint'(d) >= b) begin
         close_number(r);
         done = 1'b1;
         return;
      end
      if (unsigned_reg) lim = (64'd1 << VALUE_BITS) - 1;
      else if (neg) lim = 64'd1 << (VALUE_BITS - 1);
      else lim = (64'd1 << (VALUE_BITS - 1)) - 1;
      cut = lim / b;
      rem = lim % b;
      if (ovf || acc > cut || (acc == cut && longint'(d) > rem)) ovf = 1'b1;
      else acc = VALUE_BITS'(acc * b + longint'(d));
      got_digit = 1'b1;
      bump();
   endtask

   task automatic begin_body(input logic [7:0] c, output bit done, output conversion_t r);
      done = 1'b0;
      r = '0;
      if ((radix_reg == 0 || radix_reg == BASE_HEX) && c == CH_0) begin
         base = radix_reg;
         stage = PH_ZERO;
         bump();
      end else begin
         base = (radix_reg != 0) ? radix_reg : BASE_DEC;
         stage = PH_DIG;
         take_digit(c, done, r);
      end
   endtask

   task automatic parse_char(input logic [7:0] c, input logic s,
                             output bit done, output conversion_t r);
      done = 1'b0;
      r = '0;
      if (s) begin
         stage = PH_WS;
         neg = 1'b0;
         acc = '0;
         ovf = 1'b0;
         got_digit = 1'b0;
         pos = '0;
      end
      case (stage)
         PH_WS: begin
            if (is_blank(c)) begin
               bump();
            end else if (c == CH_PLUS || c == CH_MINUS) begin
               neg = (c == CH_MINUS);
               stage = PH_BODY;
               bump();
            end else begin
               begin_body(c, done, r);
            end
         end
         PH_BODY: begin_body(c, done, r);
         PH_ZERO: begin
            // offset is left pointing at the x until a hex digit confirms the prefix
            if (c == CH_LX || c == CH_UX) begin
               stage = PH_ZEROX;
            end else begin
               base = (base == 0) ? BASE_OCT : BASE_HEX;
               acc = '0;
               got_digit = 1'b1;
               stage = PH_DIG;
               take_digit(c, done, r);
            end
         end
         PH_ZEROX: begin
            if (char_value(c) < 16) begin
               base = BASE_HEX;
               stage = PH_DIG;
               bump();
               take_digit(c, done, r);
            end else begin
               acc = '0;
               got_digit = 1'b1;
               close_number(r);
               done = 1'b1;
            end
         end
         PH_DIG: take_digit(c, done, r);
         default: ;
      endcase
   endtask

   task automatic report(input string field, input longint unsigned want,
                         input longint unsigned actual);
      if (want != actual) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, actual);
         fail_n++;
      end
   endtask

   always @(posedge clock) begin
      conversion_t want, actual, fresh;
      bit done;
      if (reset) begin
         stage = PH_IDLE;
         neg = 1'b0;
         ovf = 1'b0;
         got_digit = 1'b0;
         acc = '0;
         base = BASE_DEC;
         pos = '0;
         radix_reg = RADIX_RESET;
         unsigned_reg = 1'b0;
         awaited.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            actual.value     = rsp_tdata[RSP_VALUE_LSB +: VALUE_BITS];
            actual.overflow  = rsp_tdata[RSP_OVF_BIT];
            actual.converted = rsp_tdata[RSP_CONV_BIT];
            actual.offset    = rsp_tdata[RSP_OFFSET_LSB +: OFFSET_BITS];
            if (awaited.size() == 0) begin
               $display("%0t: result with nothing awaited, actual value %0h ovf %0b conv %0b off %0d",
                        $time, actual.value, actual.overflow, actual.converted, actual.offset);
               fail_n++;
            end else begin
               want = awaited.pop_front();
               report("value", want.value, actual.value);
               report("overflow", want.overflow, actual.overflow);
               report("converted", want.converted, actual.converted);
               report("end_offset", want.offset, actual.offset);
            end
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_RADIX) radix_reg = csr_wdata;
            else unsigned_reg = csr_wdata[0];
         end
         if (req_tvalid && req_tready) begin
            parse_char(req_tdata, req_tuser, done, fresh);
            if (done) awaited.push_back(fresh);
         end
      end
      failures <= fail_n;
      pending  <= awaited.size();
   end

endmodule

// ===== dv/text_to_integer_parser_unit_test.sv =====
// Testbench top for the text to integer parser: stimulus, handshake idling and verdict.
module text_to_integer_parser_unit_test;
   import ttip_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUIET_LIMIT  = 4000;
   localparam int PHASE_ITEMS  = 125;
   localparam int PHASES       = 12;

   logic                     clock;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [7:0]               req_tdata = '0;
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_valid = 1'b0;
   logic                     csr_ready;
   logic                     csr_index = CSR_RADIX;
   logic [BASE_BITS-1:0]     csr_wdata = '0;

   int   failures;
   int   pending;
   int   quiet = 0;
   bit   idle_on = 1'b1;
   logic [7:0] text[$];
   logic [BASE_BITS-1:0] cur_radix = RADIX_RESET;

   text_to_integer_parser_unit DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   text_to_integer_parser_unit_check conv_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= !idle_on || ($urandom_range(0, 99) >= 25);
   end

   // watchdog: cycles without any transfer on any channel
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet <= 0;
      end else if (quiet == QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet <= quiet + 1;
      end
   end

   task automatic send_char(input logic [7:0] c, input logic s);
      while (idle_on && $urandom_range(0, 99) < 25) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= c;
      req_tuser  <= s;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic send_text();
      foreach (text[i]) send_char(text[i], i == 0);
   endtask

   task automatic send_literal(input string s, input logic [7:0] tail);
      text.delete();
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      text.push_back(tail);
      send_text();
   endtask

   // hold the sender until every result is back and the block has settled
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic idx, input logic [BASE_BITS-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(input logic [BASE_BITS-1:0] r, input logic u);
      write_reg(CSR_RADIX, r);
      // only bit 0 matters for the mode register; the rest is random
      write_reg(CSR_UNSIGNED, {5'($urandom_range(0, 31)), u});
      cur_radix = r;
   endtask

   function automatic logic [7:0] digit_char(input int v);
      if (v < 10) return CH_0 + 8'(v);
      return ($urandom_range(0, 1) ? CH_UA : CH_LA) + 8'(v - 10);
   endfunction

   function automatic logic [7:0] blank_char();
      int pick;
      pick = $urandom_range(0, 6);
      return (pick < 2) ? CH_SPACE : 8'(pick + 7);
   endfunction

   task automatic make_text();
      int kind, n, b, pick;
      logic hex_pre, zero_pre;
      longint unsigned bound_val;
      logic [7:0] tmp[$];
      text.delete();
      kind = $urandom_range(0, 99);
      if (kind < 75) begin
         if ($urandom_range(0, 1)) repeat ($urandom_range(1, 3)) text.push_back(blank_char());
         case ($urandom_range(0, 3))
            0: text.push_back(CH_PLUS);
            1: text.push_back(CH_MINUS);
            default: ;
         endcase
         hex_pre = 1'b0;
         zero_pre = 1'b0;
         if (cur_radix == 0 || cur_radix == BASE_HEX) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               text.push_back(CH_0);
               text.push_back(pick[0] ? CH_LX : CH_UX);
               hex_pre = 1'b1;
            end else if (pick < 6 && cur_radix == 0) begin
               text.push_back(CH_0);
               zero_pre = 1'b1;
            end
         end
         if (cur_radix == 0) b = hex_pre ? 16 : (zero_pre ? 8 : 10);
         else b = (cur_radix > 36) ? 36 : int'(cur_radix);
         if (b > 1 && $urandom_range(0, 9) == 0) begin
            // values at and next to the signed and unsigned limits, written in the current base
            case ($urandom_range(0, 5))
               0: bound_val = 64'h7FFF_FFFF;
               1: bound_val = 64'h8000_0000;
               2: bound_val = 64'h8000_0001;
               3: bound_val = 64'hFFFF_FFFF;
               4: bound_val = 64'h1_0000_0000;
               default: bound_val = 64'h7FFF_FFFE;
            endcase
            do begin
               tmp.push_front(digit_char(int'(bound_val % b)));
               bound_val = bound_val / b;
            end while (bound_val != 0);
            foreach (tmp[i]) text.push_back(tmp[i]);
         end else begin
            pick = $urandom_range(0, 9);
            if (pick < 7) n = $urandom_range(1, 8);
            else if (pick < 9) n = $urandom_range(9, 16);
            else n = $urandom_range(17, 40);
            repeat (n) begin
               if ($urandom_range(0, 9) == 0) text.push_back(digit_char($urandom_range(0, 35)));
               else text.push_back(digit_char($urandom_range(0, b - 1)));
            end
         end
         case ($urandom_range(0, 3))
            0: text.push_back(8'h00);
            1: text.push_back(CH_SPACE);
            2: text.push_back(8'h2e);
            default: text.push_back(8'($urandom_range(0, 255)));
         endcase
      end else if (kind < 87) begin
         case ($urandom_range(0, 3))
            0: begin
               text.push_back($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
               text.push_back(8'($urandom_range(0, 47)));
            end
            1: begin
               text.push_back(CH_0);
               text.push_back($urandom_range(0, 1) ? CH_LX : CH_UX);
               text.push_back($urandom_range(0, 2) ? digit_char($urandom_range(16, 35))
                                                   : 8'($urandom_range(0, 47)));
            end
            2: begin
               repeat ($urandom_range(1, 4)) text.push_back(blank_char());
               text.push_back(8'($urandom_range(0, 255)));
            end
            default: begin
               text.push_back(CH_0);
               text.push_back(CH_LX);
               repeat ($urandom_range(1, 4)) text.push_back(digit_char($urandom_range(0, 15)));
               text.push_back(8'h00);
            end
         endcase
      end else begin
         repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
      end
   endtask

   initial begin
      int radix_plan[PHASES];
      int mode_plan[PHASES];
      int sent;
      radix_plan = '{10, 0, 16, 8, 2, 36, 1, 63, 37, 0, 16, 10};
      mode_plan  = '{0, 1, 0, 1, 1, 0, 0, 1, 0, 0, 1, 1};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: automatic base, signed
      configure(BASE_BITS'(0), 1'b0);
      send_char(CH_0 + 8'd7, 1'b0);      // nothing open yet: ignored
      send_literal("\t-0x1", "g");
      send_literal("0x", 8'h00);         // prefix with no hex digit after it
      text = '{CH_0 + 8'd9, CH_0 + 8'd5};
      send_text();                       // left open, aborted by the next start
      send_literal("0", "8");
      send_literal("", 8'hff);
      send_literal("+", 8'h00);
      drain();
      configure(BASE_DEC, 1'b1);
      send_literal("-1", 8'h00);

      for (int p = 0; p < PHASES; p++) begin
         drain();
         if (p == PHASES - 1) configure(BASE_BITS'($urandom_range(0, 63)),
                                        1'($urandom_range(0, 1)));
         else configure(BASE_BITS'(radix_plan[p]), mode_plan[p][0]);
         idle_on = (p != 4);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            make_text();
            if ($urandom_range(0, 4) == 0 && text.size() > 1) void'(text.pop_back());
            send_text();
            sent += text.size();
            if ($urandom_range(0, 6) == 0) begin
               repeat ($urandom_range(1, 3)) send_char(8'($urandom_range(0, 255)), 1'b0);
            end
         end
      end
      idle_on = 1'b1;
      drain();
      repeat (8) @(posedge clock);

      if (failures == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/ttip_pkg.sv
design/ttip_ctrl.sv
design/ttip_dpath.sv
design/text_to_integer_parser_unit.sv
design/ttip_check.sv
dv/text_to_integer_parser_unit_check.sv
dv/text_to_integer_parser_unit_test.sv
